// ===== rtl/bsa_pkg.sv =====
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types and constants for the bitmap slot allocator: item layouts,
// request kinds, result status codes and the default pool size.
// ----------------------------------------------------------------------------
package bsa_pkg;

    // Default pool size and fixed field widths
    localparam int POOL_SLOTS_DEF = 32;
    localparam int ID_W           = 5;
    localparam int COUNT_W        = 6;

    // Reset value of the slot count register
    localparam logic [COUNT_W-1:0] SLOT_COUNT_RST = 6'd32;

    // Request kinds
    typedef enum logic {
        KIND_ACQUIRE = 1'b0,
        KIND_RELEASE = 1'b1
    } kind_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_DOUBLE  = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    // One request item
    typedef struct packed {
        kind_t             kind;
        logic [ID_W-1:0]   slot_id;
    } in_item_t;

    // One result item
    typedef struct packed {
        logic [ID_W-1:0]    granted_id;
        status_t            status;
        logic [COUNT_W-1:0] in_use;
    } out_item_t;

endpackage

// ===== rtl/bsa_eval.sv =====
// ----------------------------------------------------------------------------
// bsa_eval
// Combinational evaluation of one request against the free bitmap: pick the
// lowest free slot below the limit on acquire, check and free on release,
// and produce the next bitmap, next held count and the result item.
// ----------------------------------------------------------------------------
module bsa_eval #(
    parameter int POOL_SLOTS = bsa_pkg::POOL_SLOTS_DEF
) (
    input  bsa_pkg::in_item_t                req,
    input  logic [POOL_SLOTS-1:0]            free_map,
    input  logic [bsa_pkg::COUNT_W-1:0]      held_count,
    input  logic [bsa_pkg::COUNT_W-1:0]      limit,
    output logic [POOL_SLOTS-1:0]            free_map_next,
    output logic [bsa_pkg::COUNT_W-1:0]      held_count_next,
    output bsa_pkg::out_item_t               result
);
    import bsa_pkg::*;

    logic [POOL_SLOTS-1:0] lim_mask;
    logic [POOL_SLOTS-1:0] avail;
    logic [POOL_SLOTS-1:0] grant_oh;
    logic [POOL_SLOTS-1:0] rel_oh;
    logic [ID_W-1:0]       grant_id;
    logic                  id_invalid;
    logic                  id_free;

    // Build the limit mask and the release one-hot per slot
    always_comb
    begin
        for (int i = 0; i < POOL_SLOTS; i++)
        begin
            lim_mask[i] = (COUNT_W'(i) < limit);
            rel_oh[i]   = ({1'b0, req.slot_id} == COUNT_W'(i));
        end
    end

    // Isolate the lowest free slot and encode its index
    assign avail    = free_map & lim_mask;
    assign grant_oh = avail & (~avail + POOL_SLOTS'(1));

    always_comb
    begin
        grant_id = '0;
        for (int i = 0; i < POOL_SLOTS; i++)
        begin
            if (grant_oh[i])
            begin
                grant_id = grant_id | ID_W'(i);
            end
        end
    end

    // Release checks
    assign id_invalid = ({1'b0, req.slot_id} >= limit);
    assign id_free    = |(free_map & rel_oh);

    // Apply the request
    always_comb
    begin
        free_map_next     = free_map;
        held_count_next   = held_count;
        result.granted_id = '0;
        result.status     = ST_OK;
        unique case (req.kind)
            KIND_ACQUIRE:
            begin
                if (avail == '0)
                begin
                    result.status = ST_FULL;
                end
                else
                begin
                    result.granted_id = grant_id;
                    free_map_next     = free_map & ~grant_oh;
                    held_count_next   = held_count + COUNT_W'(1);
                end
            end
            KIND_RELEASE:
            begin
                if (id_invalid)
                begin
                    result.status = ST_INVALID;
                end
                else if (id_free)
                begin
                    result.status = ST_DOUBLE;
                end
                else
                begin
                    free_map_next   = free_map | rel_oh;
                    held_count_next = held_count - COUNT_W'(1);
                end
            end
            default:
            begin
                result.status = ST_OK;
            end
        endcase
        result.in_use = held_count_next;
    end

endmodule

// ===== rtl/bitmap_slot_allocator_core.sv =====
// Path: an accepted request waits in the request register, is evaluated there,
// and its result is written to the result register, from which it transfers out.
// Throughput: one request per cycle unless the result stalls; the read-modify-write
// of the free bitmap and held count between the request and result registers sets it.
// Reset: every slot free, held count zero, slot count 32, both stages empty.
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_core
// Free-bitmap slot allocator: grants the lowest free slot below the slot count
// on acquire or reports full, frees a slot on release, flags double and invalid releases.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_core #(
    parameter int POOL_SLOTS = bsa_pkg::POOL_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // request channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  bsa_pkg::in_item_t              in_data,
    // result channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output bsa_pkg::out_item_t             out_data,
    // slot count write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bsa_pkg::COUNT_W-1:0]    cfg_data
);
    import bsa_pkg::*;

    localparam logic [COUNT_W-1:0] MAX_LIM = COUNT_W'(POOL_SLOTS);

    logic                  req_valid_reg;
    in_item_t              req_reg;
    logic                  res_valid_reg;
    out_item_t             res_reg;
    logic [POOL_SLOTS-1:0] free_map_reg;
    logic [POOL_SLOTS-1:0] free_map_next;
    logic [COUNT_W-1:0]    held_count_reg;
    logic [COUNT_W-1:0]    held_count_next;
    logic [COUNT_W-1:0]    slot_count_reg;
    logic [COUNT_W-1:0]    limit;
    out_item_t             eval_res;
    logic                  res_open;
    logic                  advance;

    // Cap the configured count at the pool size
    assign limit = (slot_count_reg > MAX_LIM) ? MAX_LIM : slot_count_reg;

    // Handshake: the result slot opens when empty or being taken
    assign res_open  = !res_valid_reg || !out_stall;
    assign advance   = req_valid_reg && res_open;
    assign in_stall  = req_valid_reg && !res_open;
    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;
    assign cfg_ready = 1'b1;

    bsa_eval #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_eval (
        .req             (req_reg),
        .free_map        (free_map_reg),
        .held_count      (held_count_reg),
        .limit           (limit),
        .free_map_next   (free_map_next),
        .held_count_next (held_count_next),
        .result          (eval_res)
    );

    // Hold the request stage; load on every transfer in
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            req_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            req_reg <= in_data;
        end
    end

    // Advance into the result stage and commit pool state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg  <= 1'b0;
            free_map_reg   <= '1;
            held_count_reg <= '0;
        end
        else
        begin
            if (res_open)
            begin
                res_valid_reg <= req_valid_reg;
            end
            if (advance)
            begin
                free_map_reg   <= free_map_next;
                held_count_reg <= held_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= eval_res;
        end
    end

    // Slot count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= SLOT_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            slot_count_reg <= cfg_data;
        end
    end

`ifndef ASSERT_OFF
    // Held count tracks the number of held slots in the bitmap
    a_count_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg == COUNT_W'(POOL_SLOTS - $countones(free_map_reg)))
        else $error("held count disagrees with free bitmap");

    // A committed result reports the updated held count
    a_in_use_matches: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_reg.in_use == held_count_reg)
        else $error("result in_use differs from held count");

    // A granted acquire clears exactly one free bit
    a_grant_one_bit: assert property (@(posedge clk) disable iff (!rst_n)
        advance && req_reg.kind == KIND_ACQUIRE && eval_res.status == ST_OK
        |=> $countones(free_map_reg) + 1 == $past($countones(free_map_reg)))
        else $error("acquire did not take exactly one slot");

    // Only a successful acquire carries a nonzero slot id
    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.status != ST_OK |-> res_reg.granted_id == '0)
        else $error("failed request reports a granted slot");

    // Only an occupied request stage can stall the input
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> req_valid_reg && res_valid_reg && out_stall)
        else $error("input stalled without a blocked result");
`endif

endmodule

// ===== test/tb_bitmap_slot_allocator_core.sv =====
// ----------------------------------------------------------------------------
// tb_bitmap_slot_allocator_core
// Self-checking bench for the slot allocator. A short directed table covers
// reset state, both request kinds, id extremes, a one-slot pool, a zero and
// an over-range slot count, and slots held above a lowered limit. Random
// phases follow, each with its own slot count and a fill, drain or mixed
// request mix. Every accepted request is run through a local model of the
// free bitmap and held count, and each result transfer is checked against
// the oldest expected result. Both sides idle in random bursts, and the
// result side holds off for long stretches to back the block up.
// ----------------------------------------------------------------------------
module tb_bitmap_slot_allocator_core;
    import bsa_pkg::*;

    localparam int NUM_RAND    = 650;
    localparam int QUIET_AFTER = 590;
    localparam int HOLD_CYCLES = 80;
    localparam int SETTLE      = 6;
    localparam int NUM_DIR     = 21;

    typedef enum bit {
        ROW_ITEM = 1'b0,
        ROW_CFG  = 1'b1
    } row_op_t;

    // One row of the directed table; exp applies only when typed is set
    typedef struct packed {
        row_op_t            op;
        logic [COUNT_W-1:0] cfg_val;
        kind_t              kind;
        logic [ID_W-1:0]    slot_id;
        logic               typed;
        out_item_t          exp;
    } dir_row_t;

    dir_row_t dir_tab [NUM_DIR] = '{
        // fresh pool, 32 slots
        '{ROW_ITEM, 6'd0,  KIND_RELEASE, 5'd0,  1'b1, '{5'd0, ST_DOUBLE,  6'd0}},
        '{ROW_ITEM, 6'd0,  KIND_ACQUIRE, 5'd0,  1'b1, '{5'd0, ST_OK,      6'd1}},
        '{ROW_ITEM, 6'd0,  KIND_ACQUIRE, 5'd0,  1'b1, '{5'd1, ST_OK,      6'd2}},
        '{ROW_ITEM, 6'd0,  KIND_RELEASE, 5'd31, 1'b1, '{5'd0, ST_DOUBLE,  6'd2}},
        '{ROW_ITEM, 6'd0,  KIND_RELEASE, 5'd0,  1'b1, '{5'd0, ST_OK,      6'd1}},
        '{ROW_ITEM, 6'd0,  KIND_ACQUIRE, 5'd0,  1'b0, '0},
        // one slot while slots 0 and 1 are held
        '{ROW_CFG,  6'd1,  KIND_ACQUIRE, 5'd0,  1'b0, '0},
        '{ROW_ITEM, 6'd0,  KIND_ACQUIRE, 5'd0,  1'b1, '{5'd0, ST_FULL,    6'd2}},
        '{ROW_ITEM, 6'd0,  KIND_RELEASE, 5'd1,  1'b1, '{5'd0, ST_INVALID, 6'd2}},
        '{ROW_ITEM, 6'd0,  KIND_RELEASE, 5'd0,  1'b0, '0},
        '{ROW_ITEM, 6'd0,  KIND_ACQUIRE, 5'd0,  1'b0, '0},
        // zero slots: every acquire full, every release invalid
        '{ROW_CFG,  6'd0,  KIND_ACQUIRE, 5'd0,  1'b0, '0},
        '{ROW_ITEM, 6'd0,  KIND_ACQUIRE, 5'd0,  1'b1, '{5'd0, ST_FULL,    6'd2}},
        '{ROW_ITEM, 6'd0,  KIND_RELEASE, 5'd0,  1'b1, '{5'd0, ST_INVALID, 6'd2}},
        // over-range count caps at 32
        '{ROW_CFG,  6'd63, KIND_ACQUIRE, 5'd0,  1'b0, '0},
        '{ROW_ITEM, 6'd0,  KIND_RELEASE, 5'd31, 1'b1, '{5'd0, ST_DOUBLE,  6'd2}},
        '{ROW_ITEM, 6'd0,  KIND_RELEASE, 5'd1,  1'b0, '0},
        '{ROW_ITEM, 6'd0,  KIND_RELEASE, 5'd0,  1'b0, '0},
        '{ROW_ITEM, 6'd0,  KIND_ACQUIRE, 5'd31, 1'b0, '0},
        '{ROW_CFG,  6'd32, KIND_ACQUIRE, 5'd0,  1'b0, '0},
        '{ROW_ITEM, 6'd0,  KIND_RELEASE, 5'd0,  1'b0, '0}
    };

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    in_item_t           in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    out_item_t          out_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [COUNT_W-1:0] cfg_data  = '0;

    // Side band that travels with the request on the bus
    logic               req_typed  = 1'b0;
    out_item_t          req_result = '0;

    // Local copy of the pool
    logic [31:0]        free_map_q   = '1;
    logic [COUNT_W-1:0] held_q       = '0;
    logic [COUNT_W-1:0] slot_count_q = SLOT_COUNT_RST;

    out_item_t          alloc_result_q [$];
    int                 mismatches = 0;
    bit                 quiet      = 1'b0;
    bit                 hold_req   = 1'b0;

    bitmap_slot_allocator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Effective slot limit: slot count capped at the pool size
    function automatic int slot_limit();
        return (slot_count_q > 6'd32) ? 32 : int'(slot_count_q);
    endfunction

    // Apply one request to the local pool and return its result
    function automatic out_item_t alloc_predict(in_item_t req);
        logic [31:0] avail;
        int          lim;
        out_item_t   res;
        lim    = slot_limit();
        res    = '0;
        res.status = ST_OK;
        if (req.kind == KIND_ACQUIRE)
        begin
            avail = (lim >= 32) ? free_map_q : (free_map_q & ((32'd1 << lim) - 32'd1));
            if (avail == '0)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                // scan down so the lowest free slot wins
                for (int i = 31; i >= 0; i--)
                    if (avail[i])
                        res.granted_id = 5'(i);
                free_map_q[res.granted_id] = 1'b0;
                held_q = held_q + 6'd1;
            end
        end
        else
        begin
            if (int'(req.slot_id) >= lim)
                res.status = ST_INVALID;
            else if (free_map_q[req.slot_id])
                res.status = ST_DOUBLE;
            else
            begin
                free_map_q[req.slot_id] = 1'b1;
                held_q = held_q - 6'd1;
            end
        end
        res.in_use = held_q;
        return res;
    endfunction

    // Offer one request and hold it until the transfer, then maybe idle
    task automatic send_req(kind_t k, logic [ID_W-1:0] id, logic typed, out_item_t exp);
        in_item_t req;
        req.kind    = k;
        req.slot_id = id;
        in_valid   <= 1'b1;
        in_data    <= req;
        req_typed  <= typed;
        req_result <= exp;
        do @(posedge clk); while (in_stall);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    // Wait for the pool to go idle
    task automatic drain_pool();
        in_valid <= 1'b0;
        @(posedge clk);
        while (alloc_result_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_slot_count(logic [COUNT_W-1:0] val);
        drain_pool();
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Track slot count writes
    always @(posedge clk)
        if (rst_n && cfg_valid && cfg_ready)
            slot_count_q = cfg_data;

    // Predict each accepted request
    always @(posedge clk)
    begin
        out_item_t res;
        if (rst_n && in_valid && !in_stall)
        begin
            res = alloc_predict(in_data);
            alloc_result_q.push_back(req_typed ? req_result : res);
        end
    end

    // Check each result transfer against the oldest expectation
    always @(posedge clk)
    begin
        out_item_t exp;
        if (rst_n && out_valid && !out_stall)
        begin
            if (alloc_result_q.size() == 0)
            begin
                $error("unexpected result: granted_id %0d status %0d in_use %0d",
                       out_data.granted_id, out_data.status, out_data.in_use);
                mismatches++;
            end
            else
            begin
                exp = alloc_result_q.pop_front();
                if (out_data.granted_id !== exp.granted_id)
                begin
                    $error("granted_id: expected %0d, got %0d",
                           exp.granted_id, out_data.granted_id);
                    mismatches++;
                end
                if (out_data.status !== exp.status)
                begin
                    $error("status: expected %0d, got %0d", exp.status, out_data.status);
                    mismatches++;
                end
                if (out_data.in_use !== exp.in_use)
                begin
                    $error("in_use: expected %0d, got %0d", exp.in_use, out_data.in_use);
                    mismatches++;
                end
            end
        end
    end

    // Result side: random stall bursts, plus long holds on request
    initial
    begin
        int hold_left;
        int burst_left;
        logic nxt;
        hold_left  = 0;
        burst_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                nxt = 1'b1;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                nxt = 1'b1;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                nxt = 1'b1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                burst_left = $urandom_range(0, 10);
                nxt = 1'b1;
            end
            else
            begin
                nxt = 1'b0;
            end
            out_stall <= nxt;
        end
    end

    // Stimulus
    initial
    begin
        int                n_rand;
        int                phase_len;
        int                acq_pct;
        int                lim;
        int                held_ids [$];
        logic [COUNT_W-1:0] cnt;
        kind_t             k;
        logic [ID_W-1:0]   id;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed table
        for (int r = 0; r < NUM_DIR; r++)
        begin
            if (dir_tab[r].op == ROW_CFG)
                write_slot_count(dir_tab[r].cfg_val);
            else
                send_req(dir_tab[r].kind, dir_tab[r].slot_id, dir_tab[r].typed,
                         dir_tab[r].exp);
        end

        // Random phases, each with its own slot count and request mix;
        // the last phase runs to the end once the quiet part starts
        n_rand = 0;
        while (n_rand < NUM_RAND)
        begin
            case ($urandom_range(0, 9))
                0:       cnt = 6'd32;
                1:       cnt = 6'd1;
                2:       cnt = ($urandom_range(0, 1) == 0) ? 6'd0 : 6'($urandom_range(33, 63));
                default: cnt = 6'($urandom_range(2, 31));
            endcase
            write_slot_count(cnt);
            phase_len = $urandom_range(20, 80);
            case ($urandom_range(0, 2))
                0:       acq_pct = 85;
                1:       acq_pct = 15;
                default: acq_pct = 50;
            endcase
            for (int j = 0; (j < phase_len || quiet) && n_rand < NUM_RAND; j++)
            begin
                id = 5'($urandom_range(0, 31));
                if ($urandom_range(0, 99) < acq_pct)
                begin
                    k = KIND_ACQUIRE;
                end
                else
                begin
                    k = KIND_RELEASE;
                    // mostly release a slot that is actually held
                    lim = slot_limit();
                    held_ids.delete();
                    for (int i = 0; i < lim; i++)
                        if (!free_map_q[i])
                            held_ids.push_back(i);
                    if (held_ids.size() > 0 && $urandom_range(0, 99) < 85)
                        id = 5'(held_ids[$urandom_range(0, held_ids.size() - 1)]);
                end
                send_req(k, id, 1'b0, '0);
                n_rand++;
                if (n_rand == 200 || n_rand == 450)
                    hold_req = 1'b1;
                if (n_rand >= QUIET_AFTER)
                    quiet = 1'b1;
            end
        end

        // Drain and report
        in_valid <= 1'b0;
        @(posedge clk);
        while (alloc_result_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
